>>> design/gbr_pkg.sv
package gbr_pkg;

  // frame and kernel limits
  localparam int MAX_RADIUS = 3;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // pixel history ring, indexed by raster index modulo its depth
  localparam int RING_DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int LIN_W      = $clog2(MAX_WIDTH * MAX_HEIGHT);

  // reciprocal of the ring depth for the modulo
  localparam int RING_SHIFT = 32;
  localparam int REC_W      = RING_SHIFT - ADDR_W + 1;
  localparam longint unsigned RING_RECIP = (64'd1 << RING_SHIFT) / RING_DEPTH;
  localparam int MAP_LAT    = 3;

  // field widths
  localparam int DIM_W   = 11;
  localparam int POS_W   = 10;
  localparam int IDX_W   = 2 * DIM_W;
  localparam int RAD_W   = 2;
  localparam int TAP_W   = RAD_W + 1;
  localparam int COEF_W  = 16;
  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;
  localparam int WT_W    = 2 * COEF_W;
  localparam int PROD_W  = WT_W + CH_W;
  localparam int ACC_W   = PROD_W + $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1));
  localparam int FRAC_W  = 32;

  // configuration register indexes
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_RADIUS       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_CENTER  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_ONE     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_TWO     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_THREE   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 3'd6;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_IN,
    S_OUT,
    S_DEC,
    S_WWAIT,
    S_TAPS,
    S_DRAIN,
    S_ADV,
    S_CHK,
    S_PUSH
  } state_t;

  // tag that travels with an index through the address map
  typedef struct packed {
    logic wr;
    logic last;
  } map_tag_t;

endpackage

>>> design/gbr_ring_map.sv
module gbr_ring_map (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  gbr_pkg::map_tag_t              in_tag,
  input  logic [gbr_pkg::LIN_W-1:0]      lin,
  output logic                           out_valid,
  output gbr_pkg::map_tag_t              out_tag,
  output logic [gbr_pkg::ADDR_W-1:0]     addr
);

  localparam int LW = gbr_pkg::LIN_W;
  localparam int AW = gbr_pkg::ADDR_W;
  localparam int RW = gbr_pkg::REC_W;
  localparam int MW = LW + RW;
  localparam int QW = MW - gbr_pkg::RING_SHIFT;

  logic              va, vb;
  gbr_pkg::map_tag_t tag_a, tag_b;
  logic [LW-1:0]     lin_a;
  logic [MW-1:0]     prod_a;
  logic [AW:0]       rem_b;
  logic [QW-1:0]     quot;
  logic [LW-1:0]     qd;
  logic [LW-1:0]     rem_full;

  // quotient estimate is exact or one low, so one correction step follows
  always_comb begin
    quot     = prod_a[MW-1:gbr_pkg::RING_SHIFT];
    qd       = {{(LW-QW){1'b0}}, quot} * LW'(gbr_pkg::RING_DEPTH);
    rem_full = lin_a - qd;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va        <= in_valid;
      vb        <= va;
      out_valid <= vb;
    end
  end

  // reciprocal multiply, remainder, correction
  always_ff @(posedge clk) begin
    tag_a   <= in_tag;
    lin_a   <= lin;
    prod_a  <= {{RW{1'b0}}, lin} * {{LW{1'b0}}, RW'(gbr_pkg::RING_RECIP)};
    tag_b   <= tag_a;
    rem_b   <= rem_full[AW:0];
    out_tag <= tag_b;
    if (rem_b >= (AW+1)'(gbr_pkg::RING_DEPTH)) begin
      addr <= AW'(rem_b - (AW+1)'(gbr_pkg::RING_DEPTH));
    end else begin
      addr <= rem_b[AW-1:0];
    end
  end

endmodule

>>> design/gbr_lane.sv
module gbr_lane (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear,
  input  logic                         in_valid,
  input  logic                         in_last,
  input  logic [gbr_pkg::WT_W-1:0]     wt,
  input  logic [gbr_pkg::CH_W-1:0]     pix,
  output logic [gbr_pkg::ACC_W-1:0]    acc,
  output logic                         done
);

  localparam int PW = gbr_pkg::PROD_W;
  localparam int AW = gbr_pkg::ACC_W;

  logic          pv, pl;
  logic [PW-1:0] prod;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      pv   <= 1'b0;
      pl   <= 1'b0;
      done <= 1'b0;
    end else begin
      pv   <= in_valid;
      pl   <= in_valid && in_last;
      done <= pv && pl;
    end
  end

  // tap product, then accumulate
  always_ff @(posedge clk) begin
    prod <= PW'(wt) * PW'(pix);
    if (clear) begin
      acc <= '0;
    end else if (pv) begin
      acc <= acc + AW'(prod);
    end
  end

endmodule

>>> design/gbr_merge.sv
module gbr_merge (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [gbr_pkg::ACC_W-1:0]    acc_red,
  input  logic [gbr_pkg::ACC_W-1:0]    acc_green,
  input  logic [gbr_pkg::ACC_W-1:0]    acc_blue,
  input  logic                         last_in,
  output logic                         free,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gbr_pkg::CH_W-1:0]     red_out,
  output logic [gbr_pkg::CH_W-1:0]     green_out,
  output logic [gbr_pkg::CH_W-1:0]     blue_out,
  output logic                         frame_done
);

  localparam int AW = gbr_pkg::ACC_W;
  localparam int FW = gbr_pkg::FRAC_W;
  localparam int CW = gbr_pkg::CH_W;

  // drop the fraction and saturate
  function automatic logic [CW-1:0] sat_chan(input logic [AW-1:0] a);
    logic [AW-FW-1:0] whole;
    whole = a[AW-1:FW];
    if (whole > (AW-FW)'({CW{1'b1}})) begin
      return {CW{1'b1}};
    end
    return whole[CW-1:0];
  endfunction

  assign free = !out_valid || !out_stall;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push && free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && free) begin
      red_out    <= sat_chan(acc_red);
      green_out  <= sat_chan(acc_green);
      blue_out   <= sat_chan(acc_blue);
      frame_done <= last_in;
    end
  end

endmodule

>>> design/gaussian_blur_rgb_clamped_unit.sv
// Streaming RGB Gaussian blur with border replication. Pixels enter in raster order
// (action 0) and blurred pixels leave in raster order, trailing the input by
// R*W+R pixels; after the frame's last pixel, flush items (action 1) release the
// remaining outputs, and the output flagged frame_done ends the frame. The kernel
// taps are the outer product of the 1D Q0.16 weights; each channel sum is
// truncated to an integer and saturated at 255. Works on one item at a time, whether
// it only stores a pixel, does nothing, or releases an output: no new item is taken
// until the last is through, including any wait of its result on out_stall, since
// the window is read from the single-port pixel ring one tap per cycle while three
// channel lanes multiply and accumulate side by side. The ring is not cleared
// after reset; a window that reaches pixels never written gives undefined values.
module gaussian_blur_rgb_clamped_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [gbr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [gbr_pkg::COEF_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic [gbr_pkg::CH_W-1:0]          red_in,
  input  logic [gbr_pkg::CH_W-1:0]          green_in,
  input  logic [gbr_pkg::CH_W-1:0]          blue_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gbr_pkg::CH_W-1:0]          red_out,
  output logic [gbr_pkg::CH_W-1:0]          green_out,
  output logic [gbr_pkg::CH_W-1:0]          blue_out,
  output logic                              frame_done
);

  localparam int DW  = gbr_pkg::DIM_W;
  localparam int PW  = gbr_pkg::POS_W;
  localparam int IW  = gbr_pkg::IDX_W;
  localparam int RW  = gbr_pkg::RAD_W;
  localparam int TW  = gbr_pkg::TAP_W;
  localparam int CFW = gbr_pkg::COEF_W;
  localparam int LW  = gbr_pkg::LIN_W;
  localparam int AW  = gbr_pkg::ADDR_W;
  localparam int XW  = gbr_pkg::PIX_W;
  localparam int WW  = gbr_pkg::WT_W;
  localparam int CW  = gbr_pkg::CH_W;
  localparam int SW  = DW + 2;
  localparam int ML  = gbr_pkg::MAP_LAT;

  // configuration registers
  logic [RW-1:0]  radius;
  logic [CFW-1:0] coef [4];
  logic [DW-1:0]  frame_width;
  logic [DW-1:0]  frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= RW'(1);
      coef[0]      <= CFW'(32768);
      coef[1]      <= CFW'(16384);
      coef[2]      <= '0;
      coef[3]      <= '0;
      frame_width  <= DW'(1024);
      frame_height <= DW'(1024);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        gbr_pkg::REG_RADIUS:       radius       <= cfg_data[RW-1:0];
        gbr_pkg::REG_COEF_CENTER:  coef[0]      <= cfg_data;
        gbr_pkg::REG_COEF_ONE:     coef[1]      <= cfg_data;
        gbr_pkg::REG_COEF_TWO:     coef[2]      <= cfg_data;
        gbr_pkg::REG_COEF_THREE:   coef[3]      <= cfg_data;
        gbr_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[DW-1:0];
        gbr_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[DW-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [DW-1:0] w_eff, h_eff;
  logic [RW-1:0] r_eff;
  logic [IW-1:0] n_reg, lag_reg;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = DW'(1);
    end else if (frame_width > DW'(gbr_pkg::MAX_WIDTH)) begin
      w_eff = DW'(gbr_pkg::MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height == '0) begin
      h_eff = DW'(1);
    end else if (frame_height > DW'(gbr_pkg::MAX_HEIGHT)) begin
      h_eff = DW'(gbr_pkg::MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
    if (32'(radius) > gbr_pkg::MAX_RADIUS) begin
      r_eff = RW'(gbr_pkg::MAX_RADIUS);
    end else begin
      r_eff = radius;
    end
  end

  // frame size and output lag follow the registers
  always_ff @(posedge clk) begin
    n_reg   <= IW'(w_eff) * IW'(h_eff);
    lag_reg <= IW'(r_eff) * IW'(w_eff) + IW'(r_eff);
  end

  // sequencer state and position counters
  gbr_pkg::state_t state, state_next;
  logic [DW-1:0] in_row, in_row_next, in_col, in_col_next;
  logic [DW-1:0] out_row, out_row_next, out_col, out_col_next;
  logic [TW-1:0] tap_y, tap_y_next, tap_x, tap_x_next;
  logic          emit_q, emit_next;
  logic [IW-1:0] in_idx, out_idx;
  logic          act_q;
  logic [XW-1:0] pix_q;

  // shared index multiplier
  logic [DW-1:0] mul_row, mul_col;
  logic [IW-1:0] mult_sum;

  always_comb begin
    if (state == gbr_pkg::S_IN) begin
      mul_row = in_row;
      mul_col = in_col;
    end else begin
      mul_row = out_row;
      mul_col = out_col;
    end
    mult_sum = IW'(mul_row) * IW'(w_eff) + IW'(mul_col);
  end

  // decision terms
  logic          inputs_done, out_over, do_write, emit_w;
  logic [IW-1:0] in_next;
  logic [TW-1:0] span;
  logic          lanes_done, merge_free, push, lane_clear;
  logic          tap_issue, tap_last, map_wr;
  logic [DW:0]   in_col_inc, out_col_inc;

  // ring address map outputs
  logic              map_valid;
  gbr_pkg::map_tag_t map_tag;
  logic [AW-1:0]     map_addr;

  always_comb begin
    inputs_done = in_idx >= n_reg;
    out_over    = out_idx >= n_reg;
    in_next     = in_idx + IW'(1);
    do_write    = !act_q && !inputs_done;
    emit_w      = !out_over && (in_next > out_idx) && ((in_next - out_idx) > lag_reg);
    span        = {r_eff, 1'b0};
    in_col_inc  = {1'b0, in_col} + (DW+1)'(1);
    out_col_inc = {1'b0, out_col} + (DW+1)'(1);
  end

  always_comb begin
    state_next   = state;
    in_row_next  = in_row;
    in_col_next  = in_col;
    out_row_next = out_row;
    out_col_next = out_col;
    tap_y_next   = tap_y;
    tap_x_next   = tap_x;
    emit_next    = emit_q;
    map_wr       = 1'b0;
    tap_issue    = 1'b0;
    tap_last     = 1'b0;
    lane_clear   = 1'b0;
    push         = 1'b0;
    unique case (state)
      gbr_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = gbr_pkg::S_IN;
        end
      end
      gbr_pkg::S_IN:  state_next = gbr_pkg::S_OUT;
      gbr_pkg::S_OUT: state_next = gbr_pkg::S_DEC;
      gbr_pkg::S_DEC: begin
        tap_y_next = '0;
        tap_x_next = '0;
        lane_clear = 1'b1;
        if (do_write) begin
          map_wr    = 1'b1;
          emit_next = emit_w;
          if (in_col_inc >= {1'b0, w_eff}) begin
            in_col_next = '0;
            in_row_next = in_row + DW'(1);
          end else begin
            in_col_next = in_col_inc[DW-1:0];
          end
          state_next = gbr_pkg::S_WWAIT;
        end else if (!inputs_done) begin
          state_next = gbr_pkg::S_IDLE;
        end else if (out_over) begin
          in_row_next  = '0;
          in_col_next  = '0;
          out_row_next = '0;
          out_col_next = '0;
          state_next   = gbr_pkg::S_IDLE;
        end else begin
          state_next = gbr_pkg::S_TAPS;
        end
      end
      gbr_pkg::S_WWAIT: begin
        if (map_valid && map_tag.wr) begin
          state_next = emit_q ? gbr_pkg::S_TAPS : gbr_pkg::S_IDLE;
        end
      end
      gbr_pkg::S_TAPS: begin
        tap_issue = 1'b1;
        tap_last  = (tap_y == span) && (tap_x == span);
        if (tap_x == span) begin
          tap_x_next = '0;
          tap_y_next = tap_y + TW'(1);
        end else begin
          tap_x_next = tap_x + TW'(1);
        end
        if (tap_last) begin
          state_next = gbr_pkg::S_DRAIN;
        end
      end
      gbr_pkg::S_DRAIN: begin
        if (lanes_done) begin
          state_next = gbr_pkg::S_ADV;
        end
      end
      gbr_pkg::S_ADV: begin
        if (out_col_inc >= {1'b0, w_eff}) begin
          out_col_next = '0;
          out_row_next = out_row + DW'(1);
        end else begin
          out_col_next = out_col_inc[DW-1:0];
        end
        state_next = gbr_pkg::S_CHK;
      end
      gbr_pkg::S_CHK: state_next = gbr_pkg::S_PUSH;
      gbr_pkg::S_PUSH: begin
        if (merge_free) begin
          push = 1'b1;
          if (out_over) begin
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
          end
          state_next = gbr_pkg::S_IDLE;
        end
      end
      default: state_next = gbr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= gbr_pkg::S_IDLE;
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
      emit_q  <= 1'b0;
    end else begin
      state   <= state_next;
      in_row  <= in_row_next;
      in_col  <= in_col_next;
      out_row <= out_row_next;
      out_col <= out_col_next;
      emit_q  <= emit_next;
    end
  end

  always_ff @(posedge clk) begin
    tap_y <= tap_y_next;
    tap_x <= tap_x_next;
    if (state == gbr_pkg::S_IDLE && !in_stall && in_valid) begin
      act_q <= action;
      pix_q <= {red_in, green_in, blue_in};
    end
    if (state == gbr_pkg::S_IN) begin
      in_idx <= mult_sum;
    end
    if (state == gbr_pkg::S_OUT || state == gbr_pkg::S_CHK) begin
      out_idx <= mult_sum;
    end
  end

  assign in_stall = rst || (state != gbr_pkg::S_IDLE);

  // window coordinates clamped to the frame, 1d weights by distance
  logic signed [SW-1:0] ys, xs;
  logic [DW-1:0]        hmax, wmax;
  logic [PW-1:0]        y0, x0;
  logic [TW-1:0]        ay, ax;

  always_comb begin
    hmax = h_eff - DW'(1);
    wmax = w_eff - DW'(1);
    ys = $signed({2'b00, out_row}) + $signed({{(SW-TW){1'b0}}, tap_y})
       - $signed({{(SW-RW){1'b0}}, r_eff});
    xs = $signed({2'b00, out_col}) + $signed({{(SW-TW){1'b0}}, tap_x})
       - $signed({{(SW-RW){1'b0}}, r_eff});
    if (ys < 0) begin
      y0 = '0;
    end else if (ys > $signed({2'b00, hmax})) begin
      y0 = hmax[PW-1:0];
    end else begin
      y0 = ys[PW-1:0];
    end
    if (xs < 0) begin
      x0 = '0;
    end else if (xs > $signed({2'b00, wmax})) begin
      x0 = wmax[PW-1:0];
    end else begin
      x0 = xs[PW-1:0];
    end
    ay = (tap_y >= TW'(r_eff)) ? tap_y - TW'(r_eff) : TW'(r_eff) - tap_y;
    ax = (tap_x >= TW'(r_eff)) ? tap_x - TW'(r_eff) : TW'(r_eff) - tap_x;
  end

  // tap stage 1: coordinates and 2d weight
  logic          t1_v, t1_last;
  logic [PW-1:0] y1, x1;
  logic [WW-1:0] wt1;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_v    <= 1'b0;
      t1_last <= 1'b0;
    end else begin
      t1_v    <= tap_issue;
      t1_last <= tap_last;
    end
  end

  always_ff @(posedge clk) begin
    y1  <= y0;
    x1  <= x0;
    wt1 <= {{CFW{1'b0}}, coef[ay[1:0]]} * {{CFW{1'b0}}, coef[ax[1:0]]};
  end

  // tap stage 2: raster index, or the store index of a new pixel
  logic              v2;
  gbr_pkg::map_tag_t tag2;
  logic [LW-1:0]     lin2;
  logic [WW-1:0]     wt2;
  logic [LW:0]       lin_tap;

  assign lin_tap = (LW+1)'(y1) * (LW+1)'(w_eff) + (LW+1)'(x1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= map_wr || t1_v;
    end
  end

  always_ff @(posedge clk) begin
    wt2 <= wt1;
    if (map_wr) begin
      lin2      <= in_idx[LW-1:0];
      tag2.wr   <= 1'b1;
      tag2.last <= 1'b0;
    end else begin
      lin2      <= lin_tap[LW-1:0];
      tag2.wr   <= 1'b0;
      tag2.last <= t1_last;
    end
  end

  // raster index to ring address
  gbr_ring_map u_map (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_tag    (tag2),
    .lin       (lin2),
    .out_valid (map_valid),
    .out_tag   (map_tag),
    .addr      (map_addr)
  );

  // weight follows the index through the map and the ring read
  logic [WW-1:0] wt_dly [ML+1];

  always_ff @(posedge clk) begin
    wt_dly[0] <= wt2;
    for (int i = 1; i <= ML; i++) begin
      wt_dly[i] <= wt_dly[i-1];
    end
  end

  // pixel ring
  logic [XW-1:0] ring [gbr_pkg::RING_DEPTH];
  logic [XW-1:0] rd_data;
  logic          rd_valid, rd_last;

  always_ff @(posedge clk) begin
    if (map_valid && map_tag.wr) begin
      ring[map_addr] <= pix_q;
    end
    if (map_valid && !map_tag.wr) begin
      rd_data <= ring[map_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      rd_last  <= 1'b0;
    end else begin
      rd_valid <= map_valid && !map_tag.wr;
      rd_last  <= map_valid && !map_tag.wr && map_tag.last;
    end
  end

  // channel lanes
  logic [gbr_pkg::ACC_W-1:0] acc_red, acc_green, acc_blue;
  logic [2:0]                lane_done;

  gbr_lane u_lane_red (
    .clk      (clk),
    .rst      (rst),
    .clear    (lane_clear),
    .in_valid (rd_valid),
    .in_last  (rd_last),
    .wt       (wt_dly[ML]),
    .pix      (rd_data[3*CW-1:2*CW]),
    .acc      (acc_red),
    .done     (lane_done[0])
  );

  gbr_lane u_lane_green (
    .clk      (clk),
    .rst      (rst),
    .clear    (lane_clear),
    .in_valid (rd_valid),
    .in_last  (rd_last),
    .wt       (wt_dly[ML]),
    .pix      (rd_data[2*CW-1:CW]),
    .acc      (acc_green),
    .done     (lane_done[1])
  );

  gbr_lane u_lane_blue (
    .clk      (clk),
    .rst      (rst),
    .clear    (lane_clear),
    .in_valid (rd_valid),
    .in_last  (rd_last),
    .wt       (wt_dly[ML]),
    .pix      (rd_data[CW-1:0]),
    .acc      (acc_blue),
    .done     (lane_done[2])
  );

  assign lanes_done = &lane_done;

  // saturate and hold the result item
  gbr_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .acc_red    (acc_red),
    .acc_green  (acc_green),
    .acc_blue   (acc_blue),
    .last_in    (out_over),
    .free       (merge_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .frame_done (frame_done)
  );

`ifndef NO_ASSERTIONS
  a_store_in_wait: assert property (@(posedge clk) disable iff (rst)
    (map_valid && map_tag.wr) |-> (state == gbr_pkg::S_WWAIT))
    else $error("ring store outside of store wait");

  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    lanes_done |-> (state == gbr_pkg::S_DRAIN))
    else $error("lane sum finished outside of drain");

  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    (lane_done[0] == lane_done[1]) && (lane_done[1] == lane_done[2]))
    else $error("channel lanes out of step");

  a_taps_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(state == gbr_pkg::S_TAPS) |->
      ($past(state) == gbr_pkg::S_DEC || $past(state) == gbr_pkg::S_WWAIT))
    else $error("window pass started from a wrong state");
`endif

endmodule

>>> tb/gaussian_blur_rgb_clamped_unit_tb.sv
module gaussian_blur_rgb_clamped_unit_tb;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE_CYCLES = 120;
  localparam int PHASE_ITEMS = 200;

  typedef struct {
    logic [gbr_pkg::CH_W-1:0] red;
    logic [gbr_pkg::CH_W-1:0] green;
    logic [gbr_pkg::CH_W-1:0] blue;
    logic                     done;
  } blur_pix_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [gbr_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [gbr_pkg::COEF_W-1:0]     cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           action = 1'b0;
  logic [gbr_pkg::CH_W-1:0]       red_in = '0;
  logic [gbr_pkg::CH_W-1:0]       green_in = '0;
  logic [gbr_pkg::CH_W-1:0]       blue_in = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [gbr_pkg::CH_W-1:0]       red_out;
  logic [gbr_pkg::CH_W-1:0]       green_out;
  logic [gbr_pkg::CH_W-1:0]       blue_out;
  logic                           frame_done;

  gaussian_blur_rgb_clamped_unit uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .action(action),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
    .frame_done(frame_done)
  );

  always #5 clk = ~clk;

  // blur model state
  int unsigned             m_radius;
  int unsigned             m_coef [4];
  int unsigned             m_width;
  int unsigned             m_height;
  bit [gbr_pkg::PIX_W-1:0] m_ring [gbr_pkg::RING_DEPTH];
  int unsigned             m_in_row, m_in_col, m_out_row, m_out_col;

  blur_pix_t        blurred_q [$];
  int               errors = 0;
  int               items_sent = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               cycles = 0;

  function automatic int unsigned eff_width();
    if (m_width == 0) return 1;
    return (m_width > gbr_pkg::MAX_WIDTH) ? gbr_pkg::MAX_WIDTH : m_width;
  endfunction

  function automatic int unsigned eff_height();
    if (m_height == 0) return 1;
    return (m_height > gbr_pkg::MAX_HEIGHT) ? gbr_pkg::MAX_HEIGHT : m_height;
  endfunction

  function automatic void clear_positions();
    m_in_row = 0; m_in_col = 0; m_out_row = 0; m_out_col = 0;
  endfunction

  // weighted window sum around the output position, then advance it
  function automatic blur_pix_t blur_pixel(int unsigned w, int unsigned h, int unsigned n);
    blur_pix_t res;
    longint unsigned acc [3];
    longint unsigned wt;
    longint unsigned v;
    int rd, y, x;
    bit [gbr_pkg::PIX_W-1:0] px;
    rd = (m_radius > gbr_pkg::MAX_RADIUS) ? gbr_pkg::MAX_RADIUS : m_radius;
    acc[0] = 0; acc[1] = 0; acc[2] = 0;
    for (int dy = -rd; dy <= rd; dy++) begin
      y = int'(m_out_row) + dy;
      if (y < 0) y = 0;
      if (y > int'(h) - 1) y = int'(h) - 1;
      for (int dx = -rd; dx <= rd; dx++) begin
        x = int'(m_out_col) + dx;
        if (x < 0) x = 0;
        if (x > int'(w) - 1) x = int'(w) - 1;
        wt = longint'(m_coef[dy < 0 ? -dy : dy]) * longint'(m_coef[dx < 0 ? -dx : dx]);
        px = m_ring[(y * w + x) % gbr_pkg::RING_DEPTH];
        acc[0] += wt * px[23:16];
        acc[1] += wt * px[15:8];
        acc[2] += wt * px[7:0];
      end
    end
    v = acc[0] >> gbr_pkg::FRAC_W; res.red   = (v > 255) ? 8'hFF : v[7:0];
    v = acc[1] >> gbr_pkg::FRAC_W; res.green = (v > 255) ? 8'hFF : v[7:0];
    v = acc[2] >> gbr_pkg::FRAC_W; res.blue  = (v > 255) ? 8'hFF : v[7:0];
    m_out_col++;
    if (m_out_col >= w) begin
      m_out_col = 0;
      m_out_row++;
    end
    res.done = (m_out_row * w + m_out_col >= n);
    if (res.done) clear_positions();
    return res;
  endfunction

  // one accepted item; returns 1 when it releases a blurred pixel
  function automatic bit blur_step(bit act, bit [7:0] r, bit [7:0] g, bit [7:0] b,
                                   output blur_pix_t res);
    int unsigned w, h, n, rd, lag, in_idx, out_idx;
    w = eff_width();
    h = eff_height();
    n = w * h;
    rd = (m_radius > gbr_pkg::MAX_RADIUS) ? gbr_pkg::MAX_RADIUS : m_radius;
    lag = rd * w + rd;
    in_idx = m_in_row * w + m_in_col;
    out_idx = m_out_row * w + m_out_col;
    if (!act && in_idx < n) begin
      m_ring[in_idx % gbr_pkg::RING_DEPTH] = {r, g, b};
      m_in_col++;
      if (m_in_col >= w) begin
        m_in_col = 0;
        m_in_row++;
      end
      in_idx++;
      if (out_idx < n && in_idx > out_idx && in_idx - out_idx > lag) begin
        res = blur_pixel(w, h, n);
        return 1;
      end
      return 0;
    end
    if (in_idx < n) return 0;
    if (out_idx >= n) begin
      clear_positions();
      return 0;
    end
    res = blur_pixel(w, h, n);
    return 1;
  endfunction

  function automatic bit frame_inputs_done();
    return (m_in_row * eff_width() + m_in_col) >= eff_width() * eff_height();
  endfunction

  task automatic report(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result checker and receiver stalls
  always @(posedge clk) begin
    blur_pix_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (blurred_q.size() == 0) begin
          report("blurred pixel with none expected");
        end else begin
          want = blurred_q.pop_front();
          if (red_out !== want.red)
            report($sformatf("red_out %0h, want %0h", red_out, want.red));
          if (green_out !== want.green)
            report($sformatf("green_out %0h, want %0h", green_out, want.green));
          if (blue_out !== want.blue)
            report($sformatf("blue_out %0h, want %0h", blue_out, want.blue));
          if (frame_done !== want.done)
            report($sformatf("frame_done %0b, want %0b", frame_done, want.done));
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // send one item and predict its effect once accepted
  task automatic send_item(bit act, bit [7:0] r, bit [7:0] g, bit [7:0] b);
    blur_pix_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (blur_step(act, r, g, b, res)) blurred_q = {blurred_q, res};
  endtask

  task automatic send_pixel();
    bit [7:0] c [3];
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(7))
        0: c[i] = 8'h00;
        1: c[i] = 8'hFF;
        default: c[i] = 8'($urandom_range(255));
      endcase
    end
    send_item(1'b0, c[0], c[1], c[2]);
  endtask

  task automatic send_flush();
    send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // let the block go quiet before touching registers
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (blurred_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [gbr_pkg::CFG_ADDR_W-1:0] idx, int unsigned value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value[gbr_pkg::COEF_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      gbr_pkg::REG_RADIUS:       m_radius = value & 32'h3;
      gbr_pkg::REG_COEF_CENTER:  m_coef[0] = value & 32'hFFFF;
      gbr_pkg::REG_COEF_ONE:     m_coef[1] = value & 32'hFFFF;
      gbr_pkg::REG_COEF_TWO:     m_coef[2] = value & 32'hFFFF;
      gbr_pkg::REG_COEF_THREE:   m_coef[3] = value & 32'hFFFF;
      gbr_pkg::REG_FRAME_WIDTH:  m_width = value & 32'h7FF;
      gbr_pkg::REG_FRAME_HEIGHT: m_height = value & 32'h7FF;
      default: ;
    endcase
  endtask

  task automatic set_kernel(int unsigned rad, int unsigned c0, int unsigned c1,
                            int unsigned c2, int unsigned c3);
    wait_quiet();
    write_reg(gbr_pkg::REG_RADIUS, rad);
    write_reg(gbr_pkg::REG_COEF_CENTER, c0);
    write_reg(gbr_pkg::REG_COEF_ONE, c1);
    write_reg(gbr_pkg::REG_COEF_TWO, c2);
    write_reg(gbr_pkg::REG_COEF_THREE, c3);
  endtask

  task automatic set_frame(int unsigned w, int unsigned h);
    wait_quiet();
    write_reg(gbr_pkg::REG_FRAME_WIDTH, w);
    write_reg(gbr_pkg::REG_FRAME_HEIGHT, h);
  endtask

  // one whole frame of random pixels, with stray flushes and trailing pixels as noise
  task automatic run_frame(int noise_pct);
    bit started;
    started = 1'b0;
    while (!started || m_in_row != 0 || m_in_col != 0) begin
      if (!frame_inputs_done()) begin
        if ($urandom_range(99) < noise_pct) begin
          send_flush();
        end else begin
          send_pixel();
          started = 1'b1;
        end
      end else begin
        if ($urandom_range(99) < noise_pct) send_pixel();
        else send_flush();
      end
    end
  endtask

  // reset kernel on a small frame, extreme pixels, early flush, late pixel
  task automatic test_reset_kernel();
    set_frame(3, 3);
    send_item(1'b0, 8'h00, 8'h00, 8'h00);
    send_item(1'b1, 8'hFF, 8'hFF, 8'hFF);
    send_item(1'b0, 8'hFF, 8'hFF, 8'hFF);
    send_item(1'b0, 8'hFF, 8'h00, 8'hFF);
    send_item(1'b0, 8'h00, 8'hFF, 8'h00);
    send_item(1'b0, 8'h80, 8'h7F, 8'h01);
    send_item(1'b0, 8'hFE, 8'h01, 8'h80);
    send_item(1'b0, 8'h55, 8'hAA, 8'h0F);
    send_item(1'b0, 8'hAA, 8'h55, 8'hF0);
    send_item(1'b0, 8'hFF, 8'hFF, 8'hFF);
    send_item(1'b0, 8'h12, 8'h34, 8'h56);
    while (m_in_row != 0 || m_in_col != 0) send_item(1'b1, 8'h00, 8'h00, 8'h00);
  endtask

  // largest kernel and weights on white pixels saturates every channel
  task automatic test_saturation();
    set_kernel(3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    set_frame(2, 2);
    send_item(1'b0, 8'hFF, 8'hFF, 8'hFF);
    send_item(1'b0, 8'hFF, 8'hFF, 8'hFF);
    send_item(1'b0, 8'hFF, 8'hFF, 8'hFF);
    send_item(1'b0, 8'h00, 8'h00, 8'h00);
    while (m_in_row != 0 || m_in_col != 0) send_item(1'b1, 8'h00, 8'h00, 8'h00);
  endtask

  // zero sizes act as one pixel, zero radius passes with no lag
  task automatic test_zero_sizes();
    set_kernel(0, 16'hFFFF, 0, 0, 0);
    set_frame(0, 0);
    send_item(1'b0, 8'hC3, 8'h3C, 8'h99);
    send_item(1'b1, 8'h00, 8'h00, 8'h00);
  endtask

  // shrink the frame below the output position, then flush clears it
  task automatic test_shrunk_frame();
    set_kernel(1, 16'h8000, 16'h4000, 0, 0);
    set_frame(8, 4);
    repeat (32) send_pixel();
    set_frame(8, 2);
    send_item(1'b1, 8'h00, 8'h00, 8'h00);
    send_item(1'b1, 8'h00, 8'h00, 8'h00);
  endtask

  // oversized width saturates to the frame limit
  task automatic test_size_limits();
    set_kernel(0, 16'hC000, 0, 0, 0);
    set_frame(11'h7FF, 1);
    run_frame(0);
  endtask

  // random kernels and small frames under the three idle patterns
  task automatic test_random();
    int unsigned rad;
    int unsigned c [4];
    int start;
    start = items_sent;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 51 : 0;
      recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 36 : 0;
      while (items_sent < start + PHASE_ITEMS * (phase + 1)) begin
        if ($urandom_range(2) == 0) begin
          rad = $urandom_range(3);
          for (int i = 0; i < 4; i++) begin
            case ($urandom_range(5))
              0: c[i] = 0;
              1: c[i] = 16'hFFFF;
              2: c[i] = $urandom_range(16'hFFFF);
              default: c[i] = $urandom_range(16'h6000) >> i;
            endcase
          end
          set_kernel(rad, c[0], c[1], c[2], c[3]);
        end
        case ($urandom_range(9))
          0: set_frame($urandom_range(0, 40), $urandom_range(0, 3));
          1: set_frame($urandom_range(0, 2), $urandom_range(0, 12));
          default: set_frame($urandom_range(1, 12), $urandom_range(1, 6));
        endcase
        run_frame(($urandom_range(3) == 0) ? 10 : 0);
      end
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    m_radius = 1;
    m_coef[0] = 32768; m_coef[1] = 16384; m_coef[2] = 0; m_coef[3] = 0;
    m_width = 1024;
    m_height = 1024;
    clear_positions();
    @(posedge clk);

    test_reset_kernel();
    test_saturation();
    test_zero_sizes();
    test_shrunk_frame();
    test_random();
    test_size_limits();

    wait_quiet();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
